### src/band_limited_spectral_weighted_sum_top_defines.svh
// ----------------------------------------------------------------------------
// band-limited spectral weighted sum: assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BAND_LIMITED_SPECTRAL_WEIGHTED_SUM_TOP_DEFINES_SVH
`define BAND_LIMITED_SPECTRAL_WEIGHTED_SUM_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BLSWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define BLSWS_NEVER(lbl, expr, msg) \
    `BLSWS_ASSERT(lbl, !(expr), msg)

`endif

### src/blsws_pkg.sv
// ----------------------------------------------------------------------------
// blsws_pkg
// shared constants, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package blsws_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE     = 3'd0,
        REG_COLS_IN_USE     = 3'd1,
        REG_ROW_FREQ_WEIGHT = 3'd2,
        REG_COL_FREQ_WEIGHT = 3'd3,
        REG_RADIUS_LIMIT    = 3'd4,
        REG_INV_PIXEL_COUNT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic capture;
        logic do_mul;
        logic do_acc;
        logic do_rad;
        logic do_scale;
        logic do_emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

endpackage

### src/blsws_ctrl.sv
// ----------------------------------------------------------------------------
// blsws_ctrl
// sequencer: element accept, multiply, accumulate, bin finish and output load
// ----------------------------------------------------------------------------
module blsws_ctrl
    import blsws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_RAD   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.do_mul = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.do_acc = 1'b1;
                if (status.last)
                begin
                    state_next = ST_RAD;
                end
                else
                begin
                    // next element may enter while this one accumulates
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RAD:
            begin
                cmd.do_rad = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.do_scale = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.do_emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/blsws_dp.sv
// ----------------------------------------------------------------------------
// blsws_dp
// configuration registers, complex multiply-accumulate, band test,
// reciprocal scaling with rounding and saturation, output register
// ----------------------------------------------------------------------------
module blsws_dp
    import blsws_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  cmd_t                  cmd,
    output status_t               status
);

    // configuration
    logic [10:0] rows_reg;
    logic [10:0] cols_reg;
    logic [31:0] row_w_reg;
    logic [31:0] col_w_reg;
    logic [47:0] limit_reg;
    logic [23:0] inv_reg;

    // captured element
    logic [9:0]         bin_row_reg;
    logic [9:0]         bin_col_reg;
    logic signed [23:0] re_reg;
    logic signed [23:0] im_reg;
    logic signed [17:0] fac_reg;
    logic               last_reg;

    // pipeline
    logic signed [41:0] prod_re_reg;
    logic signed [41:0] prod_im_reg;
    logic signed [47:0] acc_re_reg;
    logic signed [47:0] acc_im_reg;
    logic [10:0]        dr_reg;
    logic [10:0]        dc_reg;
    logic [21:0]        dr2_reg;
    logic [21:0]        dc2_reg;
    logic [53:0]        rr_reg;
    logic [53:0]        cc_reg;
    logic [47:0]        mag_re_reg;
    logic [47:0]        mag_im_reg;
    logic               neg_re_reg;
    logic               neg_im_reg;
    logic               in_band_reg;
    logic [47:0]        hi_re_reg;
    logic [47:0]        lo_re_reg;
    logic [47:0]        hi_im_reg;
    logic [47:0]        lo_im_reg;

    // output
    logic               out_valid_reg;
    logic [9:0]         out_row_reg;
    logic [9:0]         out_col_reg;
    logic [31:0]        out_real_reg;
    logic [31:0]        out_imag_reg;

    logic [10:0]        n1;
    logic [10:0]        n2;
    logic [10:0]        dr_next;
    logic [10:0]        dc_next;
    logic [54:0]        r2;

    function automatic logic [10:0] clamp_n(input logic [10:0] cfg, input int max_n);
        logic [10:0] n;
        n = cfg;
        if (cfg == 11'd0)
        begin
            n = 11'd1;
        end
        else if ({2'b00, cfg} > 13'(max_n))
        begin
            n = 11'(max_n);
        end
        return n;
    endfunction

    function automatic logic [10:0] centred_mag(input logic [9:0] idx, input logic [10:0] n);
        logic [11:0]        half;
        logic signed [11:0] diff;
        logic [10:0]        m;
        half = ({1'b0, n} + 12'd1) >> 1;
        diff = $signed({2'b00, idx}) - $signed({1'b0, n});
        if ({2'b00, idx} < half)
        begin
            m = {1'b0, idx};
        end
        else if (diff < 0)
        begin
            m = 11'(-diff);
        end
        else
        begin
            m = 11'(diff);
        end
        return m;
    endfunction

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [41:0] p);
        logic signed [48:0] s;
        logic signed [47:0] r;
        s = {a[47], a} + {{7{p[41]}}, p};
        if (s[48] != s[47])
        begin
            r = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            r = s[47:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] round_sat(input logic [47:0] hi, input logic [47:0] lo,
                                              input logic neg);
        logic [48:0] lo_sum;
        logic [48:0] t;
        logic [32:0] q;
        logic [31:0] r;
        lo_sum = {1'b0, lo} + 49'h0080_0000_0000;
        t      = {1'b0, hi} + 49'(lo_sum[48:24]);
        q      = t[48:16];
        if (neg)
        begin
            if (q > 33'h0_8000_0000)
            begin
                q = 33'h0_8000_0000;
            end
            r = 32'(~q + 33'd1);
        end
        else
        begin
            r = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    assign n1      = clamp_n(rows_reg, MAX_ROWS);
    assign n2      = clamp_n(cols_reg, MAX_COLS);
    assign dr_next = centred_mag(bin_row_reg, n1);
    assign dc_next = centred_mag(bin_col_reg, n2);
    assign r2      = {1'b0, rr_reg} + {1'b0, cc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 11'd256;
            cols_reg  <= 11'd256;
            row_w_reg <= 32'd1;
            col_w_reg <= 32'd1;
            limit_reg <= 48'd16384;
            inv_reg   <= 24'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_IN_USE:     rows_reg  <= cfg_data[10:0];
                REG_COLS_IN_USE:     cols_reg  <= cfg_data[10:0];
                REG_ROW_FREQ_WEIGHT: row_w_reg <= cfg_data[31:0];
                REG_COL_FREQ_WEIGHT: col_w_reg <= cfg_data[31:0];
                REG_RADIUS_LIMIT:    limit_reg <= cfg_data[47:0];
                REG_INV_PIXEL_COUNT: inv_reg   <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_emit)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            else if (cmd.do_acc)
            begin
                acc_re_reg <= sat_add(acc_re_reg, prod_re_reg);
                acc_im_reg <= sat_add(acc_im_reg, prod_im_reg);
            end
            if (cmd.do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            bin_row_reg <= s_tdata[9:0];
            bin_col_reg <= s_tdata[19:10];
            re_reg      <= s_tdata[43:20];
            im_reg      <= s_tdata[67:44];
            fac_reg     <= s_tdata[85:68];
            last_reg    <= s_tlast;
        end
        if (cmd.do_mul)
        begin
            prod_re_reg <= 42'(re_reg) * 42'(fac_reg);
            prod_im_reg <= 42'(im_reg) * 42'(fac_reg);
            dr_reg      <= dr_next;
            dc_reg      <= dc_next;
        end
        if (cmd.do_acc)
        begin
            dr2_reg <= 22'(dr_reg) * 22'(dr_reg);
            dc2_reg <= 22'(dc_reg) * 22'(dc_reg);
        end
        if (cmd.do_rad)
        begin
            rr_reg     <= 54'(dr2_reg) * 54'(row_w_reg);
            cc_reg     <= 54'(dc2_reg) * 54'(col_w_reg);
            neg_re_reg <= acc_re_reg[47];
            neg_im_reg <= acc_im_reg[47];
            mag_re_reg <= acc_re_reg[47] ? 48'(-acc_re_reg) : acc_re_reg;
            mag_im_reg <= acc_im_reg[47] ? 48'(-acc_im_reg) : acc_im_reg;
        end
        if (cmd.do_scale)
        begin
            in_band_reg <= (r2 <= {7'd0, limit_reg});
            hi_re_reg   <= 48'(mag_re_reg[47:24]) * 48'(inv_reg);
            lo_re_reg   <= 48'(mag_re_reg[23:0]) * 48'(inv_reg);
            hi_im_reg   <= 48'(mag_im_reg[47:24]) * 48'(inv_reg);
            lo_im_reg   <= 48'(mag_im_reg[23:0]) * 48'(inv_reg);
        end
        if (cmd.do_emit)
        begin
            out_row_reg  <= bin_row_reg;
            out_col_reg  <= bin_col_reg;
            out_real_reg <= in_band_reg ? round_sat(hi_re_reg, lo_re_reg, neg_re_reg) : 32'd0;
            out_imag_reg <= in_band_reg ? round_sat(hi_im_reg, lo_im_reg, neg_im_reg) : 32'd0;
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_imag_reg, out_real_reg, out_col_reg, out_row_reg};

endmodule

### src/band_limited_spectral_weighted_sum_top.sv
// ----------------------------------------------------------------------------
// band_limited_spectral_weighted_sum_top
// Per-bin weighted sum of element spectra with a band limit and 1/N scaling.
//
// Slave channel: one beat per element; the beat with tlast closes the bin.
// Master channel: one beat per closed bin: row, column and scaled complex sum,
// zero when the bin's weighted squared radius exceeds the limit.
// Elements pass first through the complex multiplier and then through the
// saturating accumulator, and the next beat is captured during the accumulate
// state, so a new element enters before the last one is through.
// Closing a bin adds the radius multiply, the reciprocal partial products and
// the output load: the radius, scale and emit states follow the tlast beat's
// accumulate state, and the next element is taken back in the idle state.
// A stalled master holds its beat in the output register; a closed bin waits
// for that register to drain, so s_tready stays low meanwhile.
// Reset clears the accumulators and the output valid flag and returns the
// configuration registers to their defaults; the user must write configuration
// only while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "band_limited_spectral_weighted_sum_top_defines.svh"

module band_limited_spectral_weighted_sum_top
    import blsws_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // bin_row, bin_col, spec_real, spec_imag, scat_factor, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_row, out_col, out_real, out_imag, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    blsws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    blsws_dp
    #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    // a finished bin never overwrites a beat still held by the receiver
    `BLSWS_NEVER(a_no_overwrite, cmd.do_emit && m_tvalid && !m_tready, "output beat overwritten")
    // a new beat appears only after an output load
    `BLSWS_ASSERT(a_valid_from_load, $rose(m_tvalid) |-> $past(cmd.do_emit), "m_tvalid without load")
    // no element enters while a bin is being closed
    `BLSWS_NEVER(a_no_accept_closing, (s_tvalid && s_tready) && (cmd.do_rad || cmd.do_scale || cmd.do_emit), "element accepted during bin close")

endmodule

### dv/tb_band_limited_spectral_weighted_sum_top.sv
// ----------------------------------------------------------------------------
// tb_band_limited_spectral_weighted_sum_top
// Self-checking bench for the band-limited spectral weighted sum. Element
// beats stream in on the slave channel while a scoreboard keeps its own copy
// of the configuration and the complex accumulators. Each tlast beat adds the
// expected bin result, and every master beat is checked field by field. The
// run steps through several register settings, extremes included, with
// random gaps on both channels, a long receiver hold-off and idle drains.
// ----------------------------------------------------------------------------
module tb_band_limited_spectral_weighted_sum_top;
    import blsws_pkg::*;

    class bin_sum_scoreboard;
        typedef struct {
            logic [9:0]         row;
            logic [9:0]         col;
            logic signed [31:0] re;
            logic signed [31:0] im;
        } bin_result_t;

        bin_result_t expected_bins[$];
        logic [10:0] rows;
        logic [10:0] cols;
        logic [31:0] row_wt;
        logic [31:0] col_wt;
        logic [47:0] limit;
        logic [23:0] inv_count;
        longint      sum_re;
        longint      sum_im;
        int          errors;

        function new();
            rows      = 11'd256;
            cols      = 11'd256;
            row_wt    = 32'd1;
            col_wt    = 32'd1;
            limit     = 48'd16384;
            inv_count = 24'd256;
            sum_re    = 0;
            sum_im    = 0;
            errors    = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [47:0] val);
            case (idx)
                REG_ROWS_IN_USE:     rows      = val[10:0];
                REG_COLS_IN_USE:     cols      = val[10:0];
                REG_ROW_FREQ_WEIGHT: row_wt    = val[31:0];
                REG_COL_FREQ_WEIGHT: col_wt    = val[31:0];
                REG_RADIUS_LIMIT:    limit     = val;
                REG_INV_PIXEL_COUNT: inv_count = val[23:0];
                default: ;
            endcase
        endfunction

        function longint sat_add(longint a, longint p);
            longint s;
            s = a + p;
            if (s > 64'sh7FFF_FFFF_FFFF)
                return 64'sh7FFF_FFFF_FFFF;
            if (s < -64'sh8000_0000_0000)
                return -64'sh8000_0000_0000;
            return s;
        endfunction

        function int grid_size(logic [10:0] n, int max_n);
            if (n == 0)
                return 1;
            if (int'(n) > max_n)
                return max_n;
            return int'(n);
        endfunction

        function logic [63:0] abs_offset(logic [9:0] idx, int n);
            int off;
            off = (int'(idx) < (n + 1) / 2) ? int'(idx) : int'(idx) - n;
            return (off < 0) ? 64'(-off) : 64'(off);
        endfunction

        // round half away from zero, then clip to 32 bits
        function logic [31:0] scale(longint a);
            logic [47:0] mag;
            logic [72:0] prod;
            logic [72:0] q;
            mag  = (a < 0) ? 48'(-a) : 48'(a);
            prod = 73'(mag) * 73'(inv_count) + (73'd1 << 39);
            q    = prod >> 40;
            if (a < 0)
            begin
                if (q > 73'h8000_0000)
                    q = 73'h8000_0000;
                return -q[31:0];
            end
            if (q > 73'h7FFF_FFFF)
                q = 73'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function void note_input(logic [9:0] row, logic [9:0] col,
                                 logic signed [23:0] re, logic signed [23:0] im,
                                 logic signed [17:0] f, logic last);
            bin_result_t res;
            logic [63:0] dr;
            logic [63:0] dc;
            logic [63:0] r2;
            sum_re = sat_add(sum_re, longint'(re) * longint'(f));
            sum_im = sat_add(sum_im, longint'(im) * longint'(f));
            if (!last)
                return;
            dr = abs_offset(row, grid_size(rows, MAX_ROWS_DEF));
            dc = abs_offset(col, grid_size(cols, MAX_COLS_DEF));
            r2 = dr * dr * 64'(row_wt) + dc * dc * 64'(col_wt);
            res.row = row;
            res.col = col;
            if (r2 <= 64'(limit))
            begin
                res.re = scale(sum_re);
                res.im = scale(sum_im);
            end
            else
            begin
                res.re = 0;
                res.im = 0;
            end
            expected_bins.push_back(res);
            sum_re = 0;
            sum_im = 0;
        endfunction

        function int pending();
            return expected_bins.size();
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            bin_result_t exp_bin;
            if (expected_bins.size() == 0)
            begin
                $error("unexpected result beat: row %0d col %0d", d[9:0], d[19:10]);
                errors++;
                return;
            end
            exp_bin = expected_bins.pop_front();
            if (d[9:0] !== exp_bin.row)
            begin
                $error("out_row: expected %0d, got %0d", exp_bin.row, d[9:0]);
                errors++;
            end
            if (d[19:10] !== exp_bin.col)
            begin
                $error("out_col: expected %0d, got %0d", exp_bin.col, d[19:10]);
                errors++;
            end
            if (d[51:20] !== exp_bin.re)
            begin
                $error("out_real: expected %0d, got %0d", exp_bin.re, $signed(d[51:20]));
                errors++;
            end
            if (d[83:52] !== exp_bin.im)
            begin
                $error("out_imag: expected %0d, got %0d", exp_bin.im, $signed(d[83:52]));
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    bin_sum_scoreboard sb = new();
    bit tx_no_idle = 0;
    bit rx_no_idle = 0;
    int rx_hold_cycles = 0;
    int rx_stall = 0;
    int items_sent = 0;

    band_limited_spectral_weighted_sum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                rx_stall = pick_gap(rx_no_idle);
                m_tready <= (rx_stall == 0);
                if (rx_stall > 0)
                    rx_stall--;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [10:0] rows, input logic [10:0] cols,
                                input logic [31:0] rw, input logic [31:0] cw,
                                input logic [47:0] lim, input logic [23:0] inv);
        write_reg(REG_ROWS_IN_USE, 48'(rows));
        write_reg(REG_COLS_IN_USE, 48'(cols));
        write_reg(REG_ROW_FREQ_WEIGHT, 48'(rw));
        write_reg(REG_COL_FREQ_WEIGHT, 48'(cw));
        write_reg(REG_RADIUS_LIMIT, lim);
        write_reg(REG_INV_PIXEL_COUNT, 48'(inv));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input logic [9:0] row, input logic [9:0] col,
                             input logic [23:0] re, input logic [23:0] im,
                             input logic [17:0] f, input logic last);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, f, im, re, col, row};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(row, col, re, im, f, last);
        items_sent++;
        gap = pick_gap(tx_no_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender waits for every bin result, then for the closing pipeline
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(32'($urandom_range(0, 4000)) - 32'd2000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [17:0] rand_factor();
        case ($urandom_range(0, 5))
            0: return 18'h20000;
            1: return 18'h1FFFF;
            2: return 18'h0;
            3: return 18'(32'($urandom_range(0, 200)) - 32'd100);
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] rand_row();
        int n;
        n = sb.grid_size(sb.rows, MAX_ROWS_DEF);
        case ($urandom_range(0, 4))
            0: return 10'($urandom_range(0, 1023));
            1: return 10'($urandom_range(0, 4));
            2: return 10'(n - $urandom_range(1, 4));
            3: return 10'd1023;
            default: return 10'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic logic [9:0] rand_col();
        case ($urandom_range(0, 4))
            0: return 10'($urandom_range(0, 512));
            1: return 10'd512;
            default: return 10'($urandom_range(0, 12));
        endcase
    endfunction

    // extreme products saturate the real sum, and past 128 beats the imaginary
    task automatic send_saturating_bin();
        int len;
        len = $urandom_range(128, 140);
        for (int i = 0; i < len; i++)
            send_beat(rand_row(), rand_col(), 24'h800000, 24'h7FFFFF, 18'h20000,
                      i == len - 1);
    endtask

    task automatic send_bin();
        int len;
        int r;
        logic [23:0] re;
        logic [23:0] im;
        logic [17:0] f;
        r = $urandom_range(0, 99);
        len = (r < 75) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        for (int i = 0; i < len; i++)
        begin
            re = rand_value();
            im = rand_value();
            f  = rand_factor();
            send_beat(rand_row(), rand_col(), re, im, f, i == len - 1);
        end
    endtask

    task automatic random_config();
        logic [10:0] rows;
        logic [10:0] cols;
        logic [31:0] wt[2];
        logic [47:0] lim;
        logic [23:0] inv;
        logic [10:0] dim[2];
        for (int k = 0; k < 2; k++)
        begin
            case ($urandom_range(0, 7))
                0: dim[k] = 11'd0;
                1: dim[k] = 11'd1;
                2: dim[k] = 11'd2;
                3: dim[k] = 11'd1024;
                4: dim[k] = 11'd2047;
                5: dim[k] = 11'd1025;
                default: dim[k] = 11'($urandom_range(1, 1024));
            endcase
            case ($urandom_range(0, 4))
                0: wt[k] = 32'd0;
                1: wt[k] = 32'd1;
                2: wt[k] = 32'hFFFF_FFFF;
                3: wt[k] = 32'($urandom_range(1, 16));
                default: wt[k] = $urandom;
            endcase
        end
        rows = dim[0];
        cols = dim[1];
        case ($urandom_range(0, 4))
            0: lim = 48'd0;
            1: lim = 48'hFFFF_FFFF_FFFF;
            2: lim = 48'($urandom_range(0, 4096));
            3: lim = 48'($urandom_range(0, 1 << 20));
            default: lim = {16'($urandom), 32'($urandom)};
        endcase
        case ($urandom_range(0, 4))
            0: inv = 24'd0;
            1: inv = 24'hFFFFFF;
            2: inv = 24'd256;
            default: inv = 24'($urandom);
        endcase
        apply_config(rows, cols, wt[0], wt[1], lim, inv);
    endtask

    initial
    begin
        int phase_start;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROWS_IN_USE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset settings: extremes, band edge, rounding of halves
        send_beat(10'd0, 10'd0, 24'h7FFFFF, 24'h800000, 18'h1FFFF, 1'b1);
        send_beat(10'd255, 10'd255, 24'h800000, 24'h7FFFFF, 18'h20000, 1'b1);
        send_beat(10'd5, 10'd7, 24'd1000, -24'sd1000, 18'd65536, 1'b0);
        send_beat(10'd128, 10'd0, 24'd0, 24'd0, 18'd0, 1'b1);
        send_beat(10'd128, 10'd128, 24'd123456, -24'sd654321, 18'd777, 1'b1);
        send_beat(10'd1023, 10'd0, 24'd5000, 24'd5000, 18'd9000, 1'b1);
        send_beat(10'd0, 10'd512, 24'd5000, 24'd5000, 18'd9000, 1'b1);
        send_beat(10'd1, 10'd1, 24'd32768, -24'sd32768, 18'd65536, 1'b1);
        send_beat(10'd2, 10'd3, 24'd32767, -24'sd32767, 18'd65536, 1'b1);
        send_beat(10'd0, 10'd0, 24'h7FFFFF, 24'h1, 18'h3FFFF, 1'b0);
        send_beat(10'd0, 10'd0, -24'sd77, 24'h555555, 18'h2AAAA, 1'b0);
        send_beat(10'd90, 10'd90, 24'hAAAAAA, 24'd3, 18'h15555, 1'b1);
        send_beat(10'd127, 10'd127, 24'd0, 24'd0, 18'd0, 1'b1);
        send_beat(10'd129, 10'd1, 24'h000001, 24'hFFFFFF, 18'h1, 1'b1);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: apply_config(11'd0, 11'd2047, 32'd0, 32'd0, 48'd0, 24'hFFFFFF);
                1: apply_config(11'd1024, 11'd1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                48'hFFFF_FFFF_FFFF, 24'd0);
                2: apply_config(11'd64, 11'd33, 32'd3, 32'd5, 48'd20000, 24'd3000);
                default: random_config();
            endcase
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                tx_no_idle     = 1'b1;
                rx_hold_cycles = 300;
            end
            // every bin is in band here, so a saturated sum reaches the output
            if (phase == 0)
                send_saturating_bin();
            phase_start = items_sent;
            while (items_sent - phase_start < 30)
                send_bin();
            // now and then leave a bin open across the register change
            if ($urandom_range(0, 4) == 0)
                send_beat(rand_row(), rand_col(), rand_value(), rand_value(),
                          rand_factor(), 1'b0);
            drain();
        end

        send_beat(10'd0, 10'd0, rand_value(), rand_value(), rand_factor(), 1'b1);
        drain();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/blsws_pkg.sv
src/blsws_ctrl.sv
src/blsws_dp.sv
src/band_limited_spectral_weighted_sum_top.sv
dv/tb_band_limited_spectral_weighted_sum_top.sv
